// ===== rtl/ascii_decimal_integer_parser_assert.svh =====
`ifndef ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH
`define ASCII_DECIMAL_INTEGER_PARSER_ASSERT_SVH

// check a same-cycle implication on clk, quiet while in reset
`define ADIP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check a next-cycle implication on clk, quiet while in reset
`define ADIP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/adip_pkg.sv =====
package adip_pkg;

    typedef enum logic [1:0] {
        PH_SKIP   = 2'd0,
        PH_SIGN   = 2'd1,
        PH_DIGITS = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NODIGITS = 2'd1,
        ST_OVERFLOW = 2'd2,
        ST_ENDED    = 2'd3
    } status_t;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam logic [31:0] SIGNED_TENTH   = 32'd214748364;
    localparam logic [31:0] UNSIGNED_TENTH = 32'd429496729;
    localparam logic [3:0]  SIGNED_POS_LAST = 4'd7;
    localparam logic [3:0]  SIGNED_NEG_LAST = 4'd8;
    localparam logic [3:0]  UNSIGNED_LAST   = 4'd5;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_input;
    } item_t;

    typedef struct packed {
        logic [31:0] value;
        status_t     status;
        logic [7:0]  last_char;
        logic        ended_by_end;
    } result_t;

    typedef struct packed {
        phase_t      phase;
        logic        is_negative;
        logic [31:0] magnitude;
    } parse_state_t;

endpackage

// ===== rtl/adip_step.sv =====
module adip_step (
    input  adip_pkg::item_t        item,
    input  logic                   signed_mode,
    input  adip_pkg::parse_state_t state,
    output adip_pkg::parse_state_t state_next,
    output logic                   emit,
    output adip_pkg::result_t      result
);
    import adip_pkg::*;

    logic [7:0]  ch;
    logic        is_ws;
    logic        is_sign;
    logic        is_digit;
    logic [3:0]  digit;
    logic        in_digits;
    logic        in_skip;
    logic [31:0] n;
    logic        overflow;
    logic [31:0] accum;
    logic [31:0] final_value;
    parse_state_t cleared;

    assign ch        = item.character;
    assign is_ws     = (ch == CH_TAB) || (ch == CH_LF) || (ch == CH_VT) ||
                       (ch == CH_CR) || (ch == CH_SPACE);
    assign is_sign   = signed_mode && ((ch == CH_PLUS) || (ch == CH_MINUS));
    assign is_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit     = ch[3:0];
    assign in_digits = (state.phase == PH_DIGITS);
    assign in_skip   = (state.phase != PH_DIGITS) && (state.phase != PH_SIGN);
    assign n         = in_digits ? state.magnitude : 32'd0;

    always_comb
    begin
        if (signed_mode)
        begin
            overflow = (n > SIGNED_TENTH) ||
                       ((n == SIGNED_TENTH) &&
                        ((digit > SIGNED_NEG_LAST) ||
                         (!state.is_negative && (digit > SIGNED_POS_LAST))));
        end
        else
        begin
            overflow = (n > UNSIGNED_TENTH) ||
                       ((n == UNSIGNED_TENTH) && (digit > UNSIGNED_LAST));
        end
    end

    assign accum       = {n[28:0], 3'b000} + {n[30:0], 1'b0} + {28'd0, digit};
    assign final_value = state.is_negative ? (32'd0 - state.magnitude) : state.magnitude;
    assign cleared     = '{phase: PH_SKIP, is_negative: 1'b0, magnitude: 32'd0};

    always_comb
    begin
        state_next = cleared;
        if (!item.end_of_input)
        begin
            unique case (state.phase)
                PH_SIGN, PH_DIGITS:
                begin
                    if (is_digit && !overflow)
                    begin
                        state_next.phase       = PH_DIGITS;
                        state_next.is_negative = state.is_negative;
                        state_next.magnitude   = accum;
                    end
                end
                default:
                begin
                    if (is_ws)
                    begin
                        state_next = state;
                        state_next.phase = PH_SKIP;
                    end
                    else if (is_sign)
                    begin
                        state_next.phase       = PH_SIGN;
                        state_next.is_negative = (ch == CH_MINUS);
                        state_next.magnitude   = 32'd0;
                    end
                    else if (is_digit && !overflow)
                    begin
                        state_next.phase       = PH_DIGITS;
                        state_next.is_negative = state.is_negative;
                        state_next.magnitude   = accum;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        emit   = 1'b1;
        result = '{value: 32'd0, status: ST_NODIGITS, last_char: ch, ended_by_end: 1'b0};
        if (item.end_of_input)
        begin
            result.last_char    = 8'd0;
            result.ended_by_end = 1'b1;
            if (in_digits)
            begin
                result.value  = final_value;
                result.status = ST_OK;
            end
            else
            begin
                result.status = ST_ENDED;
            end
        end
        else if (in_skip && (is_ws || is_sign))
        begin
            emit = 1'b0;
        end
        else if (is_digit)
        begin
            emit          = overflow;
            result.status = ST_OVERFLOW;
        end
        else if (in_digits)
        begin
            result.value  = final_value;
            result.status = ST_OK;
        end
    end

endmodule

// ===== rtl/ascii_decimal_integer_parser.sv =====
// channel  | handshake             | beat
// ---------+-----------------------+------------------------------------------
// item     | item_valid/item_ready | item: character, end_of_input
// result   | result_valid/ready    | result: value, status, last_char, ended
// cfg      | cfg_valid/cfg_ready   | signed_mode
//
// One character per cycle unless results stall; item_reg -> step -> result_reg.
// The rate is set by the single digit step: one compare and one multiply by ten.
// Reset clears the parse state to the whitespace phase and sets signed mode.
// A stalled result holds the step; the item register still takes one more beat.
module ascii_decimal_integer_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  adip_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_ready,
    output adip_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic              signed_mode
);
    import adip_pkg::*;

    `include "ascii_decimal_integer_parser_assert.svh"

    item_t        item_reg;
    logic         item_vld_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    result_t      result_reg;
    result_t      step_result;
    logic         result_vld_reg;
    logic         signed_mode_reg;
    logic         step_emit;
    logic         advance;

    adip_step u_step (
        .item        (item_reg),
        .signed_mode (signed_mode_reg),
        .state       (state_reg),
        .state_next  (state_next),
        .emit        (step_emit),
        .result      (step_result)
    );

    assign advance      = item_vld_reg && (!result_vld_reg || result_ready);
    assign item_ready   = !item_vld_reg || advance;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_vld_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_vld_reg    <= 1'b0;
            result_vld_reg  <= 1'b0;
            signed_mode_reg <= 1'b1;
            state_reg       <= '{phase: PH_SKIP, is_negative: 1'b0, magnitude: 32'd0};
        end
        else
        begin
            if (item_valid && item_ready)
            begin
                item_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                item_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                state_reg <= state_next;
            end
            if (advance && step_emit)
            begin
                result_vld_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_vld_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                signed_mode_reg <= signed_mode;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (advance && step_emit)
        begin
            result_reg <= step_result;
        end
    end

    `ADIP_ASSERT_IMP(a_fail_zero, result_valid && (result.status != ST_OK),
        result.value == 32'd0, "failed parse carries a nonzero value")
    `ADIP_ASSERT_IMP(a_end_char, result_valid && result.ended_by_end,
        result.last_char == 8'd0, "end of input result carries a character")
    `ADIP_ASSERT_IMP(a_ended_flag, result_valid && (result.status == ST_ENDED),
        result.ended_by_end, "ended status without end of input")
    `ADIP_ASSERT_NXT(a_emit_clears, advance && step_emit,
        (state_reg.phase == PH_SKIP) && (state_reg.magnitude == 32'd0),
        "parse state not cleared after a result")

endmodule

// ===== tb/ascii_decimal_integer_parser_tb.sv =====
`timescale 1ns / 100ps

module ascii_decimal_integer_parser_tb;

    import adip_pkg::*;

    class parse_scoreboard;
        bit          mode;
        phase_t      phase;
        bit          neg;
        logic [31:0] mag;
        result_t     pending[$];
        int          failures;

        function new();
            mode = 1'b1;
            failures = 0;
            clear();
        endfunction

        function void clear();
            phase = PH_SKIP;
            neg = 1'b0;
            mag = '0;
        endfunction

        function void note_item(item_t it);
            result_t     r;
            logic [7:0]  ch;
            logic [3:0]  dig;
            logic [31:0] base;
            logic [31:0] signed_val;
            phase_t      ph;
            bit          over;
            bit          emit;
            emit = 1'b0;
            over = 1'b0;
            ch = it.character;
            dig = ch[3:0];
            ph = (phase == PH_SIGN || phase == PH_DIGITS) ? phase : PH_SKIP;
            signed_val = neg ? (32'd0 - mag) : mag;
            r.value = '0;
            r.status = ST_OK;
            r.last_char = '0;
            r.ended_by_end = 1'b0;
            if (it.end_of_input)
            begin
                emit = 1'b1;
                r.ended_by_end = 1'b1;
                if (ph == PH_DIGITS)
                    r.value = signed_val;
                else
                    r.status = ST_ENDED;
            end
            else if (ph == PH_SKIP && (ch == CH_TAB || ch == CH_LF || ch == CH_VT
                                       || ch == CH_CR || ch == CH_SPACE))
            begin
                phase = PH_SKIP;
            end
            else if (ph == PH_SKIP && mode && (ch == CH_MINUS || ch == CH_PLUS))
            begin
                neg = (ch == CH_MINUS);
                mag = '0;
                phase = PH_SIGN;
            end
            else if (ch >= CH_ZERO && ch <= CH_NINE)
            begin
                base = (ph == PH_DIGITS) ? mag : 32'd0;
                if (mode)
                    over = (base > SIGNED_TENTH) || (base == SIGNED_TENTH &&
                           dig > (neg ? SIGNED_NEG_LAST : SIGNED_POS_LAST));
                else
                    over = (base > UNSIGNED_TENTH) ||
                           (base == UNSIGNED_TENTH && dig > UNSIGNED_LAST);
                if (over)
                begin
                    emit = 1'b1;
                    r.status = ST_OVERFLOW;
                    r.last_char = ch;
                end
                else
                begin
                    mag = base * 32'd10 + {28'd0, dig};
                    phase = PH_DIGITS;
                end
            end
            else
            begin
                emit = 1'b1;
                r.last_char = ch;
                if (ph == PH_DIGITS)
                    r.value = signed_val;
                else
                    r.status = ST_NODIGITS;
            end
            if (emit)
            begin
                pending.push_back(r);
                clear();
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: value %h status %0d last %h end %b",
                             got.value, got.status, got.last_char, got.ended_by_end);
                return;
            end
            want = pending.pop_front();
            if (got.value !== want.value || got.status !== want.status ||
                got.last_char !== want.last_char || got.ended_by_end !== want.ended_by_end)
            begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected value %h status %0d last %h end %b,",
                              " got value %h status %0d last %h end %b"},
                             want.value, want.status, want.last_char, want.ended_by_end,
                             got.value, got.status, got.last_char, got.ended_by_end);
            end
        endfunction
    endclass

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic    signed_mode = 1'b1;

    parse_scoreboard sb = new();

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int items_sent = 0;

    logic [7:0] ws_chars [5] = '{CH_TAB, CH_LF, CH_VT, CH_CR, CH_SPACE};

    ascii_decimal_integer_parser u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .signed_mode  (signed_mode)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // long hold-off counts down here; otherwise stall at random
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            result_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end
        else
            result_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                sb.mode = signed_mode;
            if (item_valid && item_ready)
                sb.note_item(item);
            if (result_valid && result_ready)
                sb.check_result(result);
        end
    end

    task automatic send_char(input logic [7:0] c, input logic e = 1'b0);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item.character <= c;
        item.end_of_input <= e;
        do
            @(posedge clk);
        while (!item_ready);
        items_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    // drop valid, wait out every expected beat, then let the pipeline settle
    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_mode(input bit m);
        cfg_valid <= 1'b1;
        signed_mode <= m;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input bit m,
                             input bit hold);
        string           digits;
        longint unsigned lim;
        bit              neg;
        int              kind;
        int              quota;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int h = 0; h < 2; h++)
        begin
            wait_drained();
            write_mode(m ^ h[0]);
            if (hold && h == 0)
                hold_left <= 60;
            quota = items_sent + 200;
            while (items_sent < quota)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    // noise: random bytes, stray signs, early ends
                    repeat ($urandom_range(1, 4))
                    begin
                        kind = $urandom_range(0, 9);
                        if (kind == 0)
                            send_char(8'($urandom_range(0, 255)), 1'b1);
                        else if (kind < 3)
                            send_char(kind == 1 ? CH_MINUS : CH_PLUS);
                        else
                            send_char(8'($urandom_range(0, 255)));
                    end
                end
                else
                begin
                    neg = 1'b0;
                    digits = "";
                    repeat ($urandom_range(0, 3))
                        send_char(ws_chars[$urandom_range(0, 4)]);
                    if (sb.mode && $urandom_range(0, 1))
                    begin
                        neg = 1'($urandom_range(0, 1));
                        send_char(neg ? CH_MINUS : CH_PLUS);
                    end
                    kind = $urandom_range(0, 9);
                    if (kind < 4)
                        digits = $sformatf("%0d", $urandom_range(0, 999));
                    else if (kind < 7)
                    begin
                        if (sb.mode && $urandom_range(0, 3) != 0)
                            lim = neg ? 64'd2147483648 : 64'd2147483647;
                        else
                            lim = 64'd4294967295;
                        digits = $sformatf("%0d", lim + $urandom_range(0, 6) - 3);
                    end
                    else if (kind == 7)
                        digits = {"00", $sformatf("%0d", $urandom_range(0, 99999))};
                    else if (kind == 8)
                        repeat ($urandom_range(10, 12))
                            digits = {digits, $sformatf("%0d", $urandom_range(0, 9))};
                    send_text(digits);
                    if ($urandom_range(0, 9) < 3)
                        send_char(8'($urandom_range(0, 255)), 1'b1);
                    else
                        send_char(8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    initial
    begin
        do
            @(posedge clk);
        while (!rst_n);

        send_char(CH_TAB);
        send_char(CH_LF);
        send_char(CH_VT);
        send_char(CH_CR);
        send_char(CH_SPACE);
        send_text("-2147483648");
        send_char(8'hFF);
        send_char(CH_PLUS);
        send_char(8'h00, 1'b1);
        send_char(8'h00);
        send_char(8'hFF, 1'b1);
        // leave a signed number open across a mode change
        send_text("-12");
        wait_drained();
        write_mode(1'b0);
        send_char(CH_ZERO + 8'd3);
        send_char(8'h00, 1'b1);
        send_char(CH_PLUS);

        run_phase(0, 0, 1'b0, 1'b1);
        run_phase(83, 0, 1'b1, 1'b0);
        run_phase(0, 83, 1'b0, 1'b0);
        run_phase(31, 31, 1'b1, 1'b0);

        wait_drained();
        if (sb.pending.size() != 0)
        begin
            sb.failures += sb.pending.size();
            $display("missing %0d results", sb.pending.size());
        end
        if (sb.failures == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/adip_pkg.sv
rtl/adip_step.sv
rtl/ascii_decimal_integer_parser.sv
tb/ascii_decimal_integer_parser_tb.sv
